FILE: rtl/hpk_pkg.sv
package hpk_pkg;

  // parameter defaults
  localparam int NUM_BINS_DEF    = 1024;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 24;

  // fixed field widths
  localparam int SAMPLE_W  = 32;
  localparam int SCALE_W   = 32;
  localparam int IDX_W     = 10;
  localparam int VAL_W     = 32;
  localparam int BCNT_W    = 11;
  localparam int CFG_IDX_W = 2;

  localparam logic [BCNT_W-1:0] BIN_COUNT_RST = BCNT_W'(1024);

  // multiplier row: one scale digit per cell
  localparam int DIGIT_W   = 8;
  localparam int NUM_CELLS = SCALE_W / DIGIT_W;
  localparam int ACC_W     = SAMPLE_W + SCALE_W;

  localparam logic [1:0] MODE_ADD   = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;
  localparam logic [1:0] MODE_NOP   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SCALE     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT = CFG_IDX_W'(2);

  typedef struct packed {
    logic                rej;    // offset negative with nonzero scale
    logic [SAMPLE_W-1:0] diff;   // nonnegative offset from range_low
    logic [SCALE_W-1:0]  scale;
    logic [ACC_W-1:0]    acc;    // running partial product
  } cell_data_t;

endpackage

FILE: rtl/histogram_with_peak_tracking_unit.sv
// channel  | direction | handshake           | payload
// ---------+-----------+---------------------+-------------------------------------------
// request  | in        | start, busy         | mode_i, sample_i, read_index_i
// result   | out       | valid_o (one cycle) | accepted_o, bin_index_o, bin_value_o,
//          |           |                     | peak_count_o, peak_index_o
// config   | in        | cfg_we_i            | cfg_idx_i, cfg_wdata_i
//
// One request at a time. Add passes the bin map stage, NUM_CELLS = 4 multiplier
// cells, range check, bin memory read and update/write; a sample outside the domain
// skips the memory access. Read does one memory read; no-op answers from idle.
// Clear zeroes all NUM_BINS words, one memory word per cycle.
// After reset the bin memory is swept to zero with busy high.
// Results cannot be stalled; each is shown for one cycle under valid_o.
module histogram_with_peak_tracking_unit #(
  parameter int NUM_BINS    = hpk_pkg::NUM_BINS_DEF,
  parameter int COUNT_WIDTH = hpk_pkg::COUNT_WIDTH_DEF,
  parameter int FRAC_BITS   = hpk_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [hpk_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [hpk_pkg::SCALE_W-1:0]         cfg_wdata_i,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          mode_i,
  input  logic signed [hpk_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [hpk_pkg::IDX_W-1:0]           read_index_i,
  output logic                                valid_o,
  output logic                                accepted_o,
  output logic [hpk_pkg::IDX_W-1:0]           bin_index_o,
  output logic [hpk_pkg::VAL_W-1:0]           bin_value_o,
  output logic [hpk_pkg::VAL_W-1:0]           peak_count_o,
  output logic [hpk_pkg::IDX_W-1:0]           peak_index_o
);
  import hpk_pkg::*;

  localparam int AddrW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(NUM_BINS - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MAP   = 3'd1;
  localparam logic [2:0] ST_UPD   = 3'd2;
  localparam logic [2:0] ST_RDOUT = 3'd3;
  localparam logic [2:0] ST_CLEAR = 3'd4;

  // configuration
  logic signed [SAMPLE_W-1:0] range_low_q;
  logic [SCALE_W-1:0]         scale_q;
  logic [BCNT_W-1:0]          bin_count_q;
  logic [BCNT_W-1:0]          active;

  // bin memory
  logic [COUNT_WIDTH-1:0] bin_mem [NUM_BINS];
  logic                   rd_en, wr_en;
  logic [AddrW-1:0]       rd_addr, wr_addr;
  logic [COUNT_WIDTH-1:0] wr_data, rdata_q, cnt_inc;

  // control
  logic [2:0]             state_q, state_d;
  logic [AddrW-1:0]       clr_cnt_q, clr_cnt_d;
  logic                   clr_emit_q, clr_emit_d;
  logic [AddrW-1:0]       bin_q, bin_d;
  logic [IDX_W-1:0]       ridx_q, ridx_d;
  logic                   rin_q, rin_d;
  logic [COUNT_WIDTH-1:0] peak_val_q, peak_val_d;
  logic [AddrW-1:0]       peak_bin_q, peak_bin_d;

  // result registers
  logic                   valid_q, valid_d;
  logic                   accepted_q, accepted_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [VAL_W-1:0]       val_q, val_d;

  logic                   map_valid, map_ok;
  logic [AddrW-1:0]       map_bin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_low_q <= '0;
      scale_q     <= SCALE_W'(64'd1 << FRAC_BITS);
      bin_count_q <= BIN_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RANGE_LOW: range_low_q <= cfg_wdata_i;
        REG_SCALE:     scale_q     <= cfg_wdata_i;
        REG_BIN_COUNT: bin_count_q <= cfg_wdata_i[BCNT_W-1:0];
        default:       ;
      endcase
    end
  end

  assign active = (32'(bin_count_q) > 32'(NUM_BINS)) ? BCNT_W'(NUM_BINS) : bin_count_q;
  assign busy   = (state_q != ST_IDLE);

  hpk_bin_map #(
    .FracBits(FRAC_BITS),
    .BinW    (AddrW)
  ) u_bin_map (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (start && !busy && (mode_i == MODE_ADD)),
    .sample_i   (sample_i),
    .range_low_i(range_low_q),
    .scale_i    (scale_q),
    .active_i   (active),
    .valid_o    (map_valid),
    .ok_o       (map_ok),
    .bin_o      (map_bin)
  );

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= bin_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      bin_mem[wr_addr] <= wr_data;
    end
  end

  // saturating increment
  assign cnt_inc = (&rdata_q) ? rdata_q : rdata_q + COUNT_WIDTH'(1);

  always_comb begin
    state_d    = state_q;
    clr_cnt_d  = clr_cnt_q;
    clr_emit_d = clr_emit_q;
    bin_d      = bin_q;
    ridx_d     = ridx_q;
    rin_d      = rin_q;
    peak_val_d = peak_val_q;
    peak_bin_d = peak_bin_q;
    valid_d    = 1'b0;
    accepted_d = 1'b0;
    idx_d      = '0;
    val_d      = '0;
    rd_en      = 1'b0;
    rd_addr    = map_bin;
    wr_en      = 1'b0;
    wr_addr    = bin_q;
    wr_data    = cnt_inc;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          unique case (mode_i)
            MODE_ADD: begin
              state_d = ST_MAP;
            end
            MODE_READ: begin
              rd_en   = 1'b1;
              rd_addr = AddrW'(read_index_i);
              ridx_d  = read_index_i;
              rin_d   = 32'(read_index_i) < 32'(NUM_BINS);
              state_d = ST_RDOUT;
            end
            MODE_CLEAR: begin
              peak_val_d = '0;
              peak_bin_d = '0;
              clr_cnt_d  = '0;
              clr_emit_d = 1'b1;
              state_d    = ST_CLEAR;
            end
            MODE_NOP: begin
              valid_d = 1'b1;
            end
          endcase
        end
      end
      ST_MAP: begin
        if (map_valid) begin
          if (map_ok) begin
            rd_en   = 1'b1;
            bin_d   = map_bin;
            state_d = ST_UPD;
          end else begin
            valid_d = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      ST_UPD: begin
        wr_en = 1'b1;
        if (cnt_inc > peak_val_q) begin
          peak_val_d = cnt_inc;
          peak_bin_d = bin_q;
        end
        valid_d    = 1'b1;
        accepted_d = 1'b1;
        idx_d      = IDX_W'(bin_q);
        val_d      = VAL_W'(cnt_inc);
        state_d    = ST_IDLE;
      end
      ST_RDOUT: begin
        valid_d = 1'b1;
        idx_d   = ridx_q;
        val_d   = rin_q ? VAL_W'(rdata_q) : '0;
        state_d = ST_IDLE;
      end
      ST_CLEAR: begin
        wr_en     = 1'b1;
        wr_addr   = clr_cnt_q;
        wr_data   = '0;
        clr_cnt_d = clr_cnt_q + AddrW'(1);
        if (clr_cnt_q == LastAddr) begin
          valid_d    = clr_emit_q;   // sweep after reset gives no result
          clr_emit_d = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_cnt_q  <= '0;
      clr_emit_q <= 1'b0;
      peak_val_q <= '0;
      peak_bin_q <= '0;
      valid_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_cnt_q  <= clr_cnt_d;
      clr_emit_q <= clr_emit_d;
      peak_val_q <= peak_val_d;
      peak_bin_q <= peak_bin_d;
      valid_q    <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q      <= bin_d;
    ridx_q     <= ridx_d;
    rin_q      <= rin_d;
    accepted_q <= accepted_d;
    idx_q      <= idx_d;
    val_q      <= val_d;
  end

  assign valid_o      = valid_q;
  assign accepted_o   = accepted_q;
  assign bin_index_o  = idx_q;
  assign bin_value_o  = val_q;
  assign peak_count_o = VAL_W'(peak_val_q);
  assign peak_index_o = IDX_W'(peak_bin_q);

  a_map_only_when_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    map_valid |-> state_q == ST_MAP)
    else $error("bin map answered while controller was not waiting");

  a_clear_writes_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> wr_en && wr_data == '0)
    else $error("clear sweep did not write zero");

  a_peak_covers_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_UPD |=> peak_val_q >= $past(cnt_inc))
    else $error("peak below freshly updated bin count");

  a_result_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> state_q == ST_IDLE)
    else $error("result shown while a request is still in progress");

endmodule

FILE: rtl/hpk_mul_cell.sv
module hpk_mul_cell #(
  parameter int Index = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  hpk_pkg::cell_data_t data_i,
  output logic                valid_o,
  output hpk_pkg::cell_data_t data_o
);
  import hpk_pkg::*;

  logic [DIGIT_W-1:0]          digit;
  logic [SAMPLE_W+DIGIT_W-1:0] part;
  logic                        valid_q;
  cell_data_t                  data_d, data_q;

  assign digit = data_i.scale[Index*DIGIT_W +: DIGIT_W];
  assign part  = data_i.diff * digit;

  always_comb begin
    data_d     = data_i;
    data_d.acc = data_i.acc + (ACC_W'(part) << (Index * DIGIT_W));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: rtl/hpk_bin_map.sv
module hpk_bin_map #(
  parameter int FracBits = hpk_pkg::FRAC_BITS_DEF,
  parameter int BinW     = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic signed [hpk_pkg::SAMPLE_W-1:0] sample_i,
  input  logic signed [hpk_pkg::SAMPLE_W-1:0] range_low_i,
  input  logic [hpk_pkg::SCALE_W-1:0]       scale_i,
  input  logic [hpk_pkg::BCNT_W-1:0]        active_i,
  output logic                              valid_o,
  output logic                              ok_o,
  output logic [BinW-1:0]                   bin_o
);
  import hpk_pkg::*;

  logic [SAMPLE_W:0]   diff_w;
  logic                neg;
  cell_data_t          head_d, head_q;
  logic                head_valid_q;

  logic                link_valid [NUM_CELLS+1];
  cell_data_t          link_data  [NUM_CELLS+1];

  logic [ACC_W-1:0]    bin_full;
  logic                ok_d, ok_q, valid_q;
  logic [BinW-1:0]     bin_d, bin_q;

  // 33-bit offset, exact for any pair of 32-bit operands
  assign diff_w = {sample_i[SAMPLE_W-1], sample_i} - {range_low_i[SAMPLE_W-1], range_low_i};
  assign neg    = diff_w[SAMPLE_W];

  always_comb begin
    head_d.rej   = neg && (scale_i != '0);
    head_d.diff  = neg ? '0 : diff_w[SAMPLE_W-1:0];   // zero scale: negative maps to bin 0
    head_d.scale = scale_i;
    head_d.acc   = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
    end else begin
      head_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      head_q <= head_d;
    end
  end

  assign link_valid[0] = head_valid_q;
  assign link_data[0]  = head_q;

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    hpk_mul_cell #(
      .Index(k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(link_valid[k]),
      .data_i (link_data[k]),
      .valid_o(link_valid[k+1]),
      .data_o (link_data[k+1])
    );
  end

  assign bin_full = link_data[NUM_CELLS].acc >> FracBits;
  assign ok_d     = !link_data[NUM_CELLS].rej && (bin_full < ACC_W'(active_i));
  assign bin_d    = BinW'(bin_full);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= link_valid[NUM_CELLS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (link_valid[NUM_CELLS]) begin
      ok_q  <= ok_d;
      bin_q <= bin_d;
    end
  end

  assign valid_o = valid_q;
  assign ok_o    = ok_q;
  assign bin_o   = bin_q;

endmodule

FILE: dv/hpk_histogram_checker.sv
module hpk_histogram_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [hpk_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [hpk_pkg::SCALE_W-1:0]         cfg_wdata_i,
  input  logic                                start,
  input  logic                                busy,
  input  logic [1:0]                          mode_i,
  input  logic signed [hpk_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [hpk_pkg::IDX_W-1:0]           read_index_i,
  input  logic                                valid_o,
  input  logic                                accepted_o,
  input  logic [hpk_pkg::IDX_W-1:0]           bin_index_o,
  input  logic [hpk_pkg::VAL_W-1:0]           bin_value_o,
  input  logic [hpk_pkg::VAL_W-1:0]           peak_count_o,
  input  logic [hpk_pkg::IDX_W-1:0]           peak_index_o,
  output int                                  mismatch_count,
  output int                                  outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import hpk_pkg::*;

  typedef struct packed {
    logic             accepted;
    logic [IDX_W-1:0] bin_index;
    logic [VAL_W-1:0] bin_value;
    logic [VAL_W-1:0] peak_count;
    logic [IDX_W-1:0] peak_index;
  } bin_report_t;

  logic [VAL_W-1:0]           bin_counts [NUM_BINS_DEF];
  logic [VAL_W-1:0]           peak_cnt;
  logic [IDX_W-1:0]           peak_bin;
  logic signed [SAMPLE_W-1:0] range_low_q;
  logic [SCALE_W-1:0]         scale_q;
  logic [BCNT_W-1:0]          bin_count_q;
  bin_report_t                expected_reports [$];

  function automatic void wipe_histogram();
    foreach (bin_counts[i]) bin_counts[i] = '0;
    peak_cnt = '0;
    peak_bin = '0;
  endfunction

  // Applies one request to the shadow histogram and returns the report it should produce.
  function automatic bin_report_t predict_report(logic [1:0] mode,
                                                 logic signed [SAMPLE_W-1:0] smp,
                                                 logic [IDX_W-1:0] ridx);
    bin_report_t       rpt;
    longint            offset;
    longint unsigned   product;
    longint unsigned   bin;
    longint unsigned   active;
    logic              hit;
    rpt    = '0;
    active = (bin_count_q > BCNT_W'(NUM_BINS_DEF)) ? 64'(NUM_BINS_DEF) : 64'(bin_count_q);
    case (mode)
      MODE_ADD: begin
        offset = longint'(smp) - longint'(range_low_q);
        hit    = 1'b1;
        bin    = 0;
        // below range_low only a zero scale still lands in bin zero
        if (offset < 0) begin
          hit = (scale_q == '0);
        end else begin
          product = longint'(offset) * longint'({32'd0, scale_q});
          bin     = product >> FRAC_BITS_DEF;
        end
        if (hit && bin < active) begin
          if (bin_counts[bin] != '1) bin_counts[bin] = bin_counts[bin] + VAL_W'(1);
          if (bin_counts[bin] > peak_cnt) begin
            peak_cnt = bin_counts[bin];
            peak_bin = bin[IDX_W-1:0];
          end
          rpt.accepted  = 1'b1;
          rpt.bin_index = bin[IDX_W-1:0];
          rpt.bin_value = bin_counts[bin];
        end
      end
      MODE_READ: begin
        rpt.bin_index = ridx;
        rpt.bin_value = bin_counts[ridx];
      end
      MODE_CLEAR: wipe_histogram();
      default: ;
    endcase
    rpt.peak_count = peak_cnt;
    rpt.peak_index = peak_bin;
    return rpt;
  endfunction

  function automatic void flag_mismatch(string what, bin_report_t want, bin_report_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display({"%0t %s: exp acc=%0b idx=%0d val=%0d peak=%0d pidx=%0d",
                " | got acc=%0b idx=%0d val=%0d peak=%0d pidx=%0d"},
               $realtime, what, want.accepted, want.bin_index, want.bin_value,
               want.peak_count, want.peak_index, got.accepted, got.bin_index,
               got.bin_value, got.peak_count, got.peak_index);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bin_report_t got;
    bin_report_t want;
    if (!rst_ni) begin
      wipe_histogram();
      range_low_q    = '0;
      scale_q        = SCALE_W'(1) << FRAC_BITS_DEF;
      bin_count_q    = BIN_COUNT_RST;
      mismatch_count = 0;
      expected_reports.delete();
      outstanding    = 0;
    end else begin
      // the result of an earlier request retires before a new one is predicted
      if (valid_o) begin
        got = '{accepted_o, bin_index_o, bin_value_o, peak_count_o, peak_index_o};
        if (expected_reports.size() == 0) begin
          flag_mismatch("result with no request pending", '0, got);
        end else begin
          want = expected_reports.pop_front();
          if (got.accepted !== want.accepted || got.bin_index !== want.bin_index ||
              got.bin_value !== want.bin_value || got.peak_count !== want.peak_count ||
              got.peak_index !== want.peak_index)
            flag_mismatch("result mismatch", want, got);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_RANGE_LOW: range_low_q = cfg_wdata_i;
          REG_SCALE:     scale_q     = cfg_wdata_i;
          REG_BIN_COUNT: bin_count_q = cfg_wdata_i[BCNT_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy)
        expected_reports.push_back(predict_report(mode_i, sample_i, read_index_i));
      outstanding = expected_reports.size();
    end
  end

endmodule

FILE: dv/tb_histogram_with_peak_tracking_unit.sv
module tb_histogram_with_peak_tracking_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import hpk_pkg::*;

  localparam int     CYCLE_LIMIT     = 1_000_000;
  localparam int     NUM_PHASES      = 8;
  localparam int     ITEMS_PER_PHASE = 240;
  localparam int     DRAIN_CYCLES    = 12;
  localparam longint SAMPLE_MIN      = -64'sd2147483648;
  localparam longint SAMPLE_MAX      = 64'sd2147483647;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [CFG_IDX_W-1:0]       cfg_idx_i;
  logic [SCALE_W-1:0]         cfg_wdata_i;
  logic                       start;
  logic                       busy;
  logic [1:0]                 mode_i;
  logic signed [SAMPLE_W-1:0] sample_i;
  logic [IDX_W-1:0]           read_index_i;
  logic                       valid_o;
  logic                       accepted_o;
  logic [IDX_W-1:0]           bin_index_o;
  logic [VAL_W-1:0]           bin_value_o;
  logic [VAL_W-1:0]           peak_count_o;
  logic [IDX_W-1:0]           peak_index_o;

  int     mismatch_count;
  int     outstanding;
  int     cycle_count;
  longint cur_range_low;
  longint cur_scale;
  int     cur_active;
  int     hot_bins [4];

  histogram_with_peak_tracking_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .start        (start),
    .busy         (busy),
    .mode_i       (mode_i),
    .sample_i     (sample_i),
    .read_index_i (read_index_i),
    .valid_o      (valid_o),
    .accepted_o   (accepted_o),
    .bin_index_o  (bin_index_o),
    .bin_value_o  (bin_value_o),
    .peak_count_o (peak_count_o),
    .peak_index_o (peak_index_o)
  );

  hpk_histogram_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_i),
    .sample_i       (sample_i),
    .read_index_i   (read_index_i),
    .valid_o        (valid_o),
    .accepted_o     (accepted_o),
    .bin_index_o    (bin_index_o),
    .bin_value_o    (bin_value_o),
    .peak_count_o   (peak_count_o),
    .peak_index_o   (peak_index_o),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("histogram_with_peak_tracking_unit: mismatch");
      $finish;
    end
  end

  // Holds the request until the block takes it; returns on the following falling edge.
  task automatic issue(logic [1:0] mode, logic [31:0] smp, logic [IDX_W-1:0] ridx);
    start        <= 1'b1;
    mode_i       <= mode;
    sample_i     <= smp;
    read_index_i <= ridx;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic pause_start(int cycles);
    start        <= 1'b0;
    mode_i       <= 2'($urandom);
    sample_i     <= $urandom;
    read_index_i <= IDX_W'($urandom);
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic quiesce();
    start <= 1'b0;
    @(negedge clk_i);
    while (outstanding != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    while (busy) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SCALE_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
  endtask

  task automatic set_config(longint rl, longint sc, int bc);
    logic [SCALE_W-1:0] bc_word;
    quiesce();
    // junk above the 11 count bits must be dropped by the block
    bc_word = ($urandom & ~32'h7FF) | 32'(bc);
    write_reg(REG_RANGE_LOW, rl[31:0]);
    write_reg(REG_SCALE, sc[31:0]);
    write_reg(REG_SPARE, $urandom);
    write_reg(REG_BIN_COUNT, bc_word);
    cfg_we_i      <= 1'b0;
    cur_range_low  = longint'(signed'(rl[31:0]));
    cur_scale      = longint'({32'd0, sc[31:0]});
    cur_active     = (bc[10:0] > 1024) ? 1024 : int'(bc[10:0]);
    foreach (hot_bins[k]) hot_bins[k] = (cur_active > 0) ? $urandom_range(0, cur_active - 1) : 0;
  endtask

  // Sample landing in or near the given bin under the current mapping.
  function automatic logic [31:0] aim_sample(int bin);
    longint offset;
    longint smp;
    if (cur_scale == 0)
      offset = longint'($urandom_range(0, 2000)) - 1000;
    else
      offset = ((longint'(bin) << FRAC_BITS_DEF) +
                longint'($urandom_range(0, (1 << FRAC_BITS_DEF) - 1))) / cur_scale;
    smp = cur_range_low + offset;
    if (smp > SAMPLE_MAX || smp < SAMPLE_MIN) return $urandom;
    return smp[31:0];
  endfunction

  function automatic logic [31:0] stray_sample();
    longint smp;
    if ($urandom_range(0, 1) == 0) begin
      smp = cur_range_low - 1 - longint'($urandom_range(0, 99));
      if (smp < SAMPLE_MIN) return $urandom;
      return smp[31:0];
    end
    return aim_sample(cur_active + $urandom_range(0, 3));
  endfunction

  function automatic int pick_bin();
    if (cur_active == 0) return $urandom_range(0, 1023);
    if ($urandom_range(0, 9) < 6) return hot_bins[$urandom_range(0, 3)];
    return $urandom_range(0, cur_active - 1);
  endfunction

  task automatic random_item();
    int r;
    r = $urandom_range(0, 199);
    if (r < 130)      issue(MODE_ADD, aim_sample(pick_bin()), IDX_W'($urandom));
    else if (r < 145) issue(MODE_ADD, $urandom, IDX_W'($urandom));
    else if (r < 155) issue(MODE_ADD, stray_sample(), IDX_W'($urandom));
    else if (r < 170) issue(MODE_READ, $urandom, IDX_W'(pick_bin()));
    else if (r < 180) issue(MODE_READ, $urandom, IDX_W'($urandom));
    else if (r < 190) issue(MODE_NOP, $urandom, IDX_W'($urandom));
    else if (r < 193) issue(MODE_CLEAR, $urandom, IDX_W'($urandom));
    else              issue(MODE_ADD, aim_sample(pick_bin()), IDX_W'($urandom));
  endtask

  initial begin
    int gap_pct;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    start         = 1'b0;
    mode_i        = MODE_NOP;
    sample_i      = '0;
    read_index_i  = '0;
    cur_range_low = 0;
    cur_scale     = longint'(1) << FRAC_BITS_DEF;
    cur_active    = 1024;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: domain edges, ties on the peak, reads, clear, no-op
    issue(MODE_ADD, 32'd0, '0);
    issue(MODE_ADD, 32'd1023, '0);
    issue(MODE_ADD, 32'd1024, '0);
    issue(MODE_ADD, 32'hFFFF_FFFF, '0);
    issue(MODE_ADD, 32'h7FFF_FFFF, '0);
    issue(MODE_ADD, 32'h8000_0000, '0);
    repeat (3) issue(MODE_ADD, 32'd5, '0);
    repeat (3) issue(MODE_ADD, 32'd7, '0);
    issue(MODE_ADD, 32'd7, '1);
    issue(MODE_READ, '1, 10'd7);
    issue(MODE_READ, '0, 10'd0);
    issue(MODE_READ, '0, 10'd1023);
    issue(MODE_READ, '0, 10'd3);
    issue(MODE_NOP, '1, '1);
    issue(MODE_CLEAR, '0, '0);
    issue(MODE_READ, '0, 10'd7);
    issue(MODE_ADD, 32'd3, '0);
    // zero scale: a sample below range_low still counts into bin zero
    set_config(100, 0, 2);
    issue(MODE_ADD, -32'sd5, '0);
    issue(MODE_ADD, 32'd500, '0);
    set_config(0, longint'(1) << FRAC_BITS_DEF, 0);
    issue(MODE_ADD, 32'd0, '0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: set_config(-100, longint'(1) << 24, 64);
        1: set_config(SAMPLE_MIN, 0, 1);
        2: set_config(64'sd2147483392, 64'hFFFF_FFFF, 2047);
        3: set_config(1000, longint'(1) << 20, 1024);
        4: set_config(longint'(int'($urandom)), $urandom_range(1, 1 << 26), 0);
        5: set_config(-50000, longint'(1) << 28, 1025);
        6: set_config(longint'(int'($urandom)), longint'({32'd0, $urandom}),
                      $urandom_range(1, 1100));
        default: set_config(longint'(int'($urandom)), $urandom_range(1 << 20, 1 << 26),
                            $urandom_range(512, 1024));
      endcase
      gap_pct = (p == NUM_PHASES - 1 || p % 3 == 0) ? 0 : (p % 3 == 1) ? 25 : 60;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // hold off until the block has answered every request
        if (p % 2 == 1 && i == ITEMS_PER_PHASE / 2) quiesce();
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) pause_start($urandom_range(1, 17));
        random_item();
      end
    end

    quiesce();
    if (mismatch_count == 0) begin
      $display("histogram_with_peak_tracking_unit: match");
    end else begin
      $display("histogram_with_peak_tracking_unit: mismatch");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/hpk_pkg.sv
rtl/hpk_mul_cell.sv
rtl/hpk_bin_map.sv
rtl/histogram_with_peak_tracking_unit.sv
dv/hpk_histogram_checker.sv
dv/tb_histogram_with_peak_tracking_unit.sv
